### src/pcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types, constants and helper functions of the proxy collector.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int NODES_DEF = 64;
  localparam int PTR_W     = 7;
  localparam int MAX_STEPS = 64;
  localparam int STEP_W    = 7;

  localparam logic [PTR_W-1:0] NIL_PTR  = 7'd127;
  localparam logic [31:0]      EPH_UNIT = 32'h0001_0000;
  localparam logic [31:0]      EPH_MASK = 32'hffff_0000;
  localparam logic [31:0]      IDX_MASK = 32'h0000_ffff;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RETIRE  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] ref_word;
    logic [31:0] object_handle;
    logic [7:0]  routine_tag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] ref_out;
    logic        accepted;
    logic        freed_valid;
    logic [31:0] freed_handle;
    logic [7:0]  freed_tag;
    logic        last;
  } out_item_t;

  // At most one command per cycle from the controller.
  typedef struct packed {
    logic load;
    logic acquire;
    logic ret_start;
    logic ret_node;
    logic prev_rd;
    logic ret_acc;
    logic rel_start;
    logic eval;
    logic xfer;
    logic done;
  } pcr_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pool_empty;
    logic prev_ok;
    logic rel_ok;
    logic reclaim;
    logic cont;
    logic out_free;
  } pcr_sts_t;

  // Count of a node that has never been written since reset.
  function automatic logic [31:0] cnt_reset(input logic [PTR_W-1:0] idx);
    return (idx == '0) ? 32'd1 : 32'd0;
  endfunction

  // Link of a node that has never been written: the initial free chain.
  function automatic logic [PTR_W-1:0] next_reset(input logic [PTR_W-1:0] idx);
    return (idx <= 7'd1) ? NIL_PTR : idx - 7'd1;
  endfunction

endpackage

### src/proxy_collector_reclaim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proxy_collector_reclaim
// Reference-counted proxy collector with deferred reclamation over a node pool.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_data  (in_item_t)
//   out       out_valid / out_ready  out_data (out_item_t)
//
// One item at a time. Acquire and no-op go from dispatch to done. A release
// with an index outside the pool ends after its release step; otherwise each
// reclaimed node takes a read, evaluate and transfer step until a count stays
// above zero, the chain ends or the step limit is hit. A retire that pops a
// node adds a node step and, for a valid previous index, previous and accumulate
// steps; an empty pool adds none. A stalled output holds the sequencer in its
// transfer states. Reset is synchronous; no clearing pass is needed, since
// per-node valid bits stand in for the initial counts and free chain.
// ----------------------------------------------------------------------------
module proxy_collector_reclaim
  import pcr_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  pcr_cmd_t cmd;
  pcr_sts_t sts;

  pcr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  pcr_datapath #(.NODES(NODES)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data), .cmd(cmd), .sts(sts)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.xfer || cmd.done) |-> sts.out_free)
    else $error("result pushed into a full output register");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while one is in progress");

endmodule

### src/pcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module pcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_datapath
// Tail word, free stack head, node memories and the output register.
// ----------------------------------------------------------------------------
module pcr_datapath
  import pcr_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  pcr_cmd_t  cmd,
  output pcr_sts_t  sts
);

  localparam int IW = $clog2(NODES);

  // Captured item
  op_t         op_q;
  logic [31:0] ref_q;
  logic [31:0] handle_q;
  logic [7:0]  tag_q;

  // Control state
  logic [31:0]      tail;
  logic [PTR_W-1:0] free_head;
  logic [NODES-1:0] cnt_vld;
  logic [NODES-1:0] nxt_vld;
  logic             pend_valid;

  // Working registers
  logic [31:0]       myref;
  logic              acc_q;
  logic [31:0]       refout_q;
  logic [IW-1:0]     idx;
  logic              drop_one;
  logic [STEP_W-1:0] steps;
  logic              cont_q;
  logic [IW-1:0]     node_q;
  logic [31:0]       eph_adj;
  logic [31:0]       cur_handle;
  logic [7:0]        cur_tag;
  logic [31:0]       pend_handle;
  logic [7:0]        pend_tag;

  // Memory ports
  logic              cnt_we, nxt_we, obj_we;
  logic [IW-1:0]     cnt_waddr, nxt_waddr, cnt_raddr, nxt_raddr;
  logic [31:0]       cnt_wdata, cnt_q;
  logic [PTR_W-1:0]  nxt_wdata, nxt_q;
  logic [39:0]       obj_q;
  logic              cnt_rv, nxt_rv;
  logic [IW-1:0]     cnt_ra, nxt_ra;

  logic [31:0]       cnt_val, drop_val, rsrc;
  logic [PTR_W-1:0]  nxt_val;
  logic [IW-1:0]     prev_idx;
  logic [STEP_W-1:0] steps_n;

  assign cnt_val  = cnt_rv ? cnt_q : cnt_reset(PTR_W'(cnt_ra));
  assign nxt_val  = nxt_rv ? nxt_q : next_reset(PTR_W'(nxt_ra));
  assign drop_val = drop_one ? 32'd1 : EPH_UNIT;
  assign rsrc     = (op_q == OP_RETIRE) ? myref : ref_q;
  assign prev_idx = myref[IW-1:0];
  assign steps_n  = steps + STEP_W'(1);

  assign sts.op         = op_q;
  assign sts.pool_empty = (free_head >= PTR_W'(NODES));
  assign sts.prev_ok    = ((myref & IDX_MASK) < 32'(NODES));
  assign sts.rel_ok     = ((rsrc & IDX_MASK) < 32'(NODES));
  assign sts.reclaim    = (cnt_val == drop_val);
  assign sts.cont       = cont_q;
  assign sts.out_free   = !out_valid || out_ready;

  // Memory port selection
  always_comb begin
    cnt_we    = cmd.ret_node || cmd.ret_acc || cmd.eval;
    cnt_waddr = idx;
    cnt_wdata = cnt_val - drop_val;
    if (cmd.ret_node) begin
      cnt_waddr = free_head[IW-1:0];
      cnt_wdata = 32'd2;
    end else if (cmd.ret_acc) begin
      cnt_waddr = prev_idx;
      cnt_wdata = cnt_val + eph_adj;
    end

    nxt_we    = cmd.ret_node || cmd.ret_acc || (cmd.eval && sts.reclaim);
    nxt_waddr = idx;
    nxt_wdata = free_head;
    if (cmd.ret_node) begin
      nxt_waddr = free_head[IW-1:0];
      nxt_wdata = NIL_PTR;
    end else if (cmd.ret_acc) begin
      nxt_waddr = prev_idx;
      nxt_wdata = PTR_W'(node_q);
    end

    obj_we    = cmd.ret_acc;
    cnt_raddr = cmd.prev_rd ? prev_idx : idx;
    nxt_raddr = cmd.ret_start ? free_head[IW-1:0] : idx;
  end

  pcr_ram #(.WIDTH(32), .DEPTH(NODES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_q)
  );

  pcr_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_q)
  );

  pcr_ram #(.WIDTH(40), .DEPTH(NODES)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(prev_idx), .wdata({handle_q, tag_q}),
    .raddr(idx), .rdata(obj_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tail       <= '0;
      free_head  <= PTR_W'(NODES - 1);
      cnt_vld    <= '0;
      nxt_vld    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.done || (cmd.xfer && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (nxt_we) begin
        nxt_vld[nxt_waddr] <= 1'b1;
      end
      if (cmd.load) begin
        pend_valid <= 1'b0;
      end
      if (cmd.acquire || cmd.ret_start) begin
        tail <= tail + EPH_UNIT;
      end
      if (cmd.ret_node) begin
        free_head <= nxt_val;
        tail      <= 32'(free_head[IW-1:0]);
      end
      if (cmd.eval && sts.reclaim) begin
        free_head <= PTR_W'(idx);
      end
      if (cmd.xfer) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cnt_rv <= cnt_vld[cnt_raddr];
    cnt_ra <= cnt_raddr;
    nxt_rv <= nxt_vld[nxt_raddr];
    nxt_ra <= nxt_raddr;
    if (cmd.load) begin
      op_q     <= in_data.operation;
      ref_q    <= in_data.ref_word;
      handle_q <= in_data.object_handle;
      tag_q    <= in_data.routine_tag;
      acc_q    <= 1'b1;
      refout_q <= '0;
    end
    if (cmd.acquire) begin
      refout_q <= tail;
    end
    if (cmd.ret_start) begin
      myref <= tail;
      if (sts.pool_empty) begin
        acc_q <= 1'b0;
      end
    end
    if (cmd.ret_node) begin
      node_q  <= free_head[IW-1:0];
      // The tail word here already carries the retire's own reference.
      eph_adj <= (tail & EPH_MASK) - 32'd1;
    end
    if (cmd.rel_start) begin
      idx      <= rsrc[IW-1:0];
      drop_one <= 1'b0;
      steps    <= '0;
    end
    if (cmd.eval && sts.reclaim) begin
      cur_handle <= obj_q[39:8];
      cur_tag    <= obj_q[7:0];
      idx        <= nxt_val[IW-1:0];
      drop_one   <= 1'b1;
      steps      <= steps_n;
      cont_q     <= (nxt_val < PTR_W'(NODES)) && (steps_n < STEP_W'(MAX_STEPS));
    end
    // One reclamation is held back so that the final one can carry last.
    if (cmd.xfer) begin
      pend_handle <= cur_handle;
      pend_tag    <= cur_tag;
    end
    if (cmd.xfer && pend_valid) begin
      out_data.ref_out      <= '0;
      out_data.accepted     <= acc_q;
      out_data.freed_valid  <= 1'b1;
      out_data.freed_handle <= pend_handle;
      out_data.freed_tag    <= pend_tag;
      out_data.last         <= 1'b0;
    end
    if (cmd.done) begin
      out_data.ref_out      <= pend_valid ? 32'd0 : refout_q;
      out_data.accepted     <= acc_q;
      out_data.freed_valid  <= pend_valid;
      out_data.freed_handle <= pend_valid ? pend_handle : 32'd0;
      out_data.freed_tag    <= pend_valid ? pend_tag : 8'd0;
      out_data.last         <= 1'b1;
    end
  end

endmodule

### src/pcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_ctrl
// Sequencer: dispatches one item and walks the reclamation chain.
// ----------------------------------------------------------------------------
module pcr_ctrl
  import pcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pcr_sts_t sts,
  output pcr_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DISP = 10'b00_0000_0010,
    S_NODE = 10'b00_0000_0100,
    S_PREV = 10'b00_0000_1000,
    S_ACC  = 10'b00_0001_0000,
    S_REL  = 10'b00_0010_0000,
    S_READ = 10'b00_0100_0000,
    S_EVAL = 10'b00_1000_0000,
    S_XFER = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_ACQUIRE: begin
            cmd.acquire = 1'b1;
            state_next  = S_DONE;
          end
          OP_RELEASE: state_next = S_REL;
          OP_RETIRE: begin
            cmd.ret_start = 1'b1;
            state_next    = sts.pool_empty ? S_REL : S_NODE;
          end
          default: state_next = S_DONE;
        endcase
      end
      // The free-stack link of the popped node is on the read port here.
      S_NODE: begin
        cmd.ret_node = 1'b1;
        state_next   = sts.prev_ok ? S_PREV : S_REL;
      end
      S_PREV: begin
        cmd.prev_rd = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.ret_acc = 1'b1;
        state_next  = S_REL;
      end
      S_REL: begin
        cmd.rel_start = 1'b1;
        state_next    = sts.rel_ok ? S_READ : S_DONE;
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.reclaim ? S_XFER : S_DONE;
      end
      S_XFER: begin
        if (sts.out_free) begin
          cmd.xfer   = 1'b1;
          state_next = sts.cont ? S_READ : S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
